FILE: design/gmwc_pkg.sv
// shared types, codes and helpers for the gzip member wrapper checker
// no dependencies; used by every module of the block

package gmwc_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0]  MAGIC1       = 8'h1f;
  localparam logic [7:0]  MAGIC2       = 8'h8b;
  localparam logic [7:0]  DEFLATED     = 8'h08;
  localparam logic [7:0]  FLAG_REJECT  = 8'h22;  // encrypted or continued
  localparam int unsigned FEXTRA_BIT   = 2;      // flag bit positions
  localparam int unsigned FILENAME     = 3;
  localparam int unsigned COMMENTS     = 4;
  localparam logic [31:0] CRC_POLY     = 32'hedb88320;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 3;

  typedef enum logic [1:0] {
    OP_WRAP = 2'd0,
    OP_DATA = 2'd1,
    OP_EOI  = 2'd2,
    OP_BAD  = 2'd3
  } item_kind_t;

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_TIME    = 4'd4,
    PH_XFLOS   = 4'd5,
    PH_XLEN    = 4'd6,
    PH_EXTRA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_DATA    = 4'd10,
    PH_TCRC    = 4'd11,
    PH_TLEN    = 4'd12,
    PH_DONE    = 4'd13,
    PH_ERR     = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_HDR_DONE = 3'd1,
    ST_OK       = 3'd2,
    ST_HDR_ERR  = 3'd3,
    ST_TAIL_ERR = 3'd4,
    ST_CRC_ERR  = 3'd5,
    ST_LEN_ERR  = 3'd6,
    ST_SEQ_ERR  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_COMMENT = 2'd2
  } out_kind_t;

  // classified item as it sits in the queue
  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  data;
    logic        zero;
  } item_t;

  // one result as it leaves the block
  typedef struct packed {
    logic [7:0]  header_flags;
    logic [31:0] mod_time;
    logic [7:0]  out_byte;
    status_t     status;
  } result_t;

  // header section that follows the one just finished
  function automatic phase_t next_section(input logic [7:0] flags, input phase_t done);
    phase_t nxt;
    if (done < PH_EXTRA && flags[FEXTRA_BIT]) begin
      nxt = PH_XLEN;
    end else if (done < PH_NAME && flags[FILENAME]) begin
      nxt = PH_NAME;
    end else if (done < PH_COMMENT && flags[COMMENTS]) begin
      nxt = PH_COMMENT;
    end else begin
      nxt = PH_DATA;
    end
    return nxt;
  endfunction

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/gzip_member_wrapper_checker.sv
// gzip member wrapper checker: an accepted item passes the input register, which loads on
// accept, then the queue, then the result register that drives out_tvalid; throughput one item
// per cycle while out_tready is high, set by the byte-wide crc-32 and phase update in the parser
// every accepted item gives exactly one result item; while out_tready is low the queue and
// the input register take QUEUE_DEPTH + 1 more items before in_tready drops
// synchronous active-low reset: parser expects the first magic byte, crc all ones

module gzip_member_wrapper_checker #(
  parameter int unsigned QUEUE_DEPTH = gmwc_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gmwc_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] byte_value
  input  logic [gmwc_pkg::IN_USER_W-1:0]    in_tuser,   // [1:0] opcode
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] status, [10:3] out_byte, [42:11] mod_time, [50:43] header_flags,
  // [55:51] zero
  output logic [gmwc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [gmwc_pkg::OUT_USER_W-1:0]   out_tuser   // [0] out_valid, [2:1] out_kind
);

  // front end to queue
  logic             f_valid;
  logic             f_ready;
  gmwc_pkg::item_t  f_item;

  // queue to parser
  logic             q_valid;
  logic             q_ready;
  gmwc_pkg::item_t  q_item;

  // front end registers each item and tags it by opcode
  gmwc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_item    (f_item)
  );

  // decouples front end from parser so each side can stall alone
  gmwc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // header/trailer state machine, crc and length, output register
  gmwc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: design/gmwc_front.sv
// front end: input register, classifies each accepted item
// depends on gmwc_pkg

module gmwc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gmwc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [gmwc_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              f_valid,
  input  logic                              f_ready,
  output gmwc_pkg::item_t                   f_item
);

  logic             f_valid_r;
  logic             f_valid_nxt;
  gmwc_pkg::item_t  f_item_r;
  gmwc_pkg::item_t  f_item_nxt;

  assign in_tready = !f_valid_r || f_ready;
  assign f_valid   = f_valid_r;
  assign f_item    = f_item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    f_item_nxt  = f_item_r;
    if (in_tready) begin
      f_valid_nxt = in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      f_item_nxt.kind = gmwc_pkg::item_kind_t'(in_tuser);
      f_item_nxt.data = in_tdata[7:0];
      f_item_nxt.zero = (in_tdata[7:0] == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_item_r <= f_item_nxt;
  end

endmodule

FILE: design/gmwc_queue.sv
// short item queue between front end and parser
// depends on gmwc_pkg

module gmwc_queue #(
  parameter int unsigned DEPTH = gmwc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  gmwc_pkg::item_t  wr_item,
  output logic             rd_valid,
  input  logic             rd_ready,
  output gmwc_pkg::item_t  rd_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gmwc_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: design/gmwc_back.sv
// parser: header/trailer state machine, crc-32 and length, result register
// depends on gmwc_pkg

module gmwc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  gmwc_pkg::item_t                   q_item,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gmwc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [gmwc_pkg::OUT_USER_W-1:0]   out_tuser
);

  gmwc_pkg::phase_t   phase_r, phase_nxt;
  gmwc_pkg::status_t  err_r, err_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [15:0]        extra_r, extra_nxt;
  logic [31:0]        time_r, time_nxt;
  logic [31:0]        crc_r, crc_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        trail_r, trail_nxt;

  logic               o_valid_r, o_valid_nxt;
  gmwc_pkg::result_t  o_res_r, o_res_nxt;
  logic               o_emit_r, o_emit_nxt;
  gmwc_pkg::out_kind_t o_kind_r, o_kind_nxt;

  logic               pop;
  logic [7:0]         b;
  logic [15:0]        xlen_full;
  logic [15:0]        extra_dec;
  logic [31:0]        trail_upd;
  logic [31:0]        time_upd;
  logic               hdr_adv_ok;

  assign q_ready   = !o_valid_r || out_tready;
  assign pop       = q_valid && q_ready;
  assign b         = q_item.data;
  assign xlen_full = {b, extra_r[7:0]};
  assign extra_dec = extra_r - 16'd1;
  assign trail_upd = trail_r | ({24'd0, b} << {cnt_r, 3'b000});
  assign time_upd  = time_r | ({24'd0, b} << {cnt_r, 3'b000});
  assign hdr_adv_ok = 1'b1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    if (pop) begin
      if (q_item.kind == gmwc_pkg::OP_EOI) begin
        phase_nxt = gmwc_pkg::PH_MAGIC1;
      end else if (phase_r == gmwc_pkg::PH_ERR) begin
        phase_nxt = phase_r;
      end else if (q_item.kind == gmwc_pkg::OP_BAD) begin
        phase_nxt = gmwc_pkg::PH_ERR;
        err_nxt   = gmwc_pkg::ST_SEQ_ERR;
      end else if (q_item.kind == gmwc_pkg::OP_DATA) begin
        if (phase_r != gmwc_pkg::PH_DATA) begin
          phase_nxt = gmwc_pkg::PH_ERR;
          err_nxt   = gmwc_pkg::ST_SEQ_ERR;
        end
      end else begin
        unique case (phase_r)
          gmwc_pkg::PH_MAGIC1: begin
            if (b == gmwc_pkg::MAGIC1) begin
              phase_nxt = gmwc_pkg::PH_MAGIC2;
            end else begin
              phase_nxt = gmwc_pkg::PH_ERR;
              err_nxt   = gmwc_pkg::ST_HDR_ERR;
            end
          end
          gmwc_pkg::PH_MAGIC2: begin
            if (b == gmwc_pkg::MAGIC2) begin
              phase_nxt = gmwc_pkg::PH_METHOD;
            end else begin
              phase_nxt = gmwc_pkg::PH_ERR;
              err_nxt   = gmwc_pkg::ST_HDR_ERR;
            end
          end
          gmwc_pkg::PH_METHOD: begin
            if (b == gmwc_pkg::DEFLATED) begin
              phase_nxt = gmwc_pkg::PH_FLAGS;
            end else begin
              phase_nxt = gmwc_pkg::PH_ERR;
              err_nxt   = gmwc_pkg::ST_HDR_ERR;
            end
          end
          gmwc_pkg::PH_FLAGS: begin
            if ((b & gmwc_pkg::FLAG_REJECT) != 8'd0) begin
              phase_nxt = gmwc_pkg::PH_ERR;
              err_nxt   = gmwc_pkg::ST_HDR_ERR;
            end else begin
              phase_nxt = gmwc_pkg::PH_TIME;
            end
          end
          gmwc_pkg::PH_TIME: begin
            if (cnt_r == 2'd3) begin
              phase_nxt = gmwc_pkg::PH_XFLOS;
            end
          end
          gmwc_pkg::PH_XFLOS: begin
            if (cnt_r == 2'd1) begin
              phase_nxt = gmwc_pkg::next_section(flags_r, gmwc_pkg::PH_XFLOS);
            end
          end
          gmwc_pkg::PH_XLEN: begin
            if (cnt_r != 2'd0) begin
              phase_nxt = (xlen_full == 16'd0) ?
                          gmwc_pkg::next_section(flags_r, gmwc_pkg::PH_EXTRA) :
                          gmwc_pkg::PH_EXTRA;
            end
          end
          gmwc_pkg::PH_EXTRA: begin
            if (extra_dec == 16'd0) begin
              phase_nxt = gmwc_pkg::next_section(flags_r, gmwc_pkg::PH_EXTRA);
            end
          end
          gmwc_pkg::PH_NAME, gmwc_pkg::PH_COMMENT: begin
            if (q_item.zero) begin
              phase_nxt = gmwc_pkg::next_section(flags_r, phase_r);
            end
          end
          gmwc_pkg::PH_DATA: begin
            phase_nxt = gmwc_pkg::PH_TCRC;
          end
          gmwc_pkg::PH_TCRC: begin
            if (cnt_r == 2'd3) begin
              if (trail_upd != ~crc_r) begin
                phase_nxt = gmwc_pkg::PH_ERR;
                err_nxt   = gmwc_pkg::ST_CRC_ERR;
              end else begin
                phase_nxt = gmwc_pkg::PH_TLEN;
              end
            end
          end
          gmwc_pkg::PH_TLEN: begin
            if (cnt_r == 2'd3) begin
              if (trail_upd != len_r) begin
                phase_nxt = gmwc_pkg::PH_ERR;
                err_nxt   = gmwc_pkg::ST_LEN_ERR;
              end else begin
                phase_nxt = gmwc_pkg::PH_DONE;
              end
            end
          end
          default: begin
            // wrapper byte after a finished member
            phase_nxt = gmwc_pkg::PH_ERR;
            err_nxt   = gmwc_pkg::ST_SEQ_ERR;
          end
        endcase
      end
    end
  end

  // datapath updates and result
  always_comb begin
    flags_nxt   = flags_r;
    cnt_nxt     = cnt_r;
    extra_nxt   = extra_r;
    time_nxt    = time_r;
    crc_nxt     = crc_r;
    len_nxt     = len_r;
    trail_nxt   = trail_r;
    o_valid_nxt = o_valid_r;
    o_res_nxt   = o_res_r;
    o_emit_nxt  = o_emit_r;
    o_kind_nxt  = o_kind_r;

    if (out_tready) begin
      o_valid_nxt = 1'b0;
    end

    if (pop) begin
      o_valid_nxt       = 1'b1;
      o_emit_nxt        = 1'b0;
      o_kind_nxt        = gmwc_pkg::KIND_DATA;
      o_res_nxt.out_byte = 8'd0;
      o_res_nxt.status  = gmwc_pkg::ST_BUSY;

      if (q_item.kind == gmwc_pkg::OP_EOI) begin
        priority if (phase_r == gmwc_pkg::PH_ERR) begin
          o_res_nxt.status = err_r;
        end else if (phase_r == gmwc_pkg::PH_DONE) begin
          o_res_nxt.status = gmwc_pkg::ST_OK;
        end else if (phase_r <= gmwc_pkg::PH_COMMENT) begin
          o_res_nxt.status = gmwc_pkg::ST_HDR_ERR;
        end else begin
          o_res_nxt.status = gmwc_pkg::ST_TAIL_ERR;
        end
      end else begin
        priority if (phase_r == gmwc_pkg::PH_ERR) begin
          o_res_nxt.status = err_r;
        end else if (phase_nxt == gmwc_pkg::PH_ERR) begin
          o_res_nxt.status = err_nxt;
        end else if (phase_nxt == gmwc_pkg::PH_DATA && phase_r != gmwc_pkg::PH_DATA &&
                     hdr_adv_ok) begin
          o_res_nxt.status = gmwc_pkg::ST_HDR_DONE;
        end else if (phase_nxt == gmwc_pkg::PH_DONE && phase_r == gmwc_pkg::PH_TLEN) begin
          o_res_nxt.status = gmwc_pkg::ST_OK;
        end else begin
          o_res_nxt.status = gmwc_pkg::ST_BUSY;
        end
      end

      // register updates only while not in error
      if (q_item.kind == gmwc_pkg::OP_DATA && phase_r == gmwc_pkg::PH_DATA) begin
        crc_nxt            = gmwc_pkg::crc32_byte(crc_r, b);
        len_nxt            = len_r + 32'd1;
        o_emit_nxt         = 1'b1;
        o_kind_nxt         = gmwc_pkg::KIND_DATA;
        o_res_nxt.out_byte = b;
      end else if (q_item.kind == gmwc_pkg::OP_WRAP) begin
        unique case (phase_r)
          gmwc_pkg::PH_FLAGS: begin
            flags_nxt = b;
            cnt_nxt   = 2'd0;
          end
          gmwc_pkg::PH_TIME: begin
            time_nxt = time_upd;
            cnt_nxt  = cnt_r + 2'd1;
          end
          gmwc_pkg::PH_XFLOS: begin
            cnt_nxt = (cnt_r == 2'd1) ? 2'd0 : 2'd1;
          end
          gmwc_pkg::PH_XLEN: begin
            if (cnt_r == 2'd0) begin
              extra_nxt = {8'd0, b};
              cnt_nxt   = 2'd1;
            end else begin
              extra_nxt = xlen_full;
              cnt_nxt   = 2'd0;
            end
          end
          gmwc_pkg::PH_EXTRA: begin
            extra_nxt = extra_dec;
            cnt_nxt   = 2'd0;
          end
          gmwc_pkg::PH_NAME, gmwc_pkg::PH_COMMENT: begin
            cnt_nxt = 2'd0;
            if (!q_item.zero) begin
              o_emit_nxt         = 1'b1;
              o_kind_nxt         = (phase_r == gmwc_pkg::PH_NAME) ?
                                   gmwc_pkg::KIND_NAME : gmwc_pkg::KIND_COMMENT;
              o_res_nxt.out_byte = b;
            end
          end
          gmwc_pkg::PH_DATA: begin
            trail_nxt = {24'd0, b};
            cnt_nxt   = 2'd1;
          end
          gmwc_pkg::PH_TCRC: begin
            trail_nxt = trail_upd;
            cnt_nxt   = cnt_r + 2'd1;
            if (cnt_r == 2'd3 && trail_upd == ~crc_r) begin
              trail_nxt = 32'd0;
            end
          end
          gmwc_pkg::PH_TLEN: begin
            trail_nxt = trail_upd;
            cnt_nxt   = cnt_r + 2'd1;
          end
          default: begin
            // magic, method, done and error phases touch no registers
          end
        endcase
      end

      // captured fields shown before an end-of-input return to reset
      o_res_nxt.mod_time     = time_nxt;
      o_res_nxt.header_flags = flags_nxt;

      if (q_item.kind == gmwc_pkg::OP_EOI) begin
        flags_nxt = 8'd0;
        cnt_nxt   = 2'd0;
        extra_nxt = 16'd0;
        time_nxt  = 32'd0;
        crc_nxt   = 32'hffffffff;
        len_nxt   = 32'd0;
        trail_nxt = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= gmwc_pkg::PH_MAGIC1;
      err_r     <= gmwc_pkg::ST_BUSY;
      flags_r   <= 8'd0;
      cnt_r     <= 2'd0;
      extra_r   <= 16'd0;
      time_r    <= 32'd0;
      crc_r     <= 32'hffffffff;
      len_r     <= 32'd0;
      trail_r   <= 32'd0;
      o_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      err_r     <= err_nxt;
      flags_r   <= flags_nxt;
      cnt_r     <= cnt_nxt;
      extra_r   <= extra_nxt;
      time_r    <= time_nxt;
      crc_r     <= crc_nxt;
      len_r     <= len_nxt;
      trail_r   <= trail_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_res_r  <= o_res_nxt;
    o_emit_r <= o_emit_nxt;
    o_kind_r <= o_kind_nxt;
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {{(gmwc_pkg::OUT_DATA_W - $bits(gmwc_pkg::result_t)){1'b0}}, o_res_r};
  assign out_tuser  = {o_kind_r, o_emit_r};

endmodule
